[rtl/bda_pkg.sv]
// Package for the binary to decimal ASCII converter.
// Holds the power-of-ten table, character codes and the controller/datapath interface types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bda_pkg;

	localparam int unsigned POS_W = 5;
	localparam int unsigned DIGIT_W = 4;

	localparam logic [POS_W-1:0] NARROW_DIGITS = 5'd10;
	localparam logic [POS_W-1:0] WIDE_DIGITS = 5'd20;
	localparam logic [POS_W-1:0] NARROW_TOP = 5'd9;
	localparam logic [POS_W-1:0] WIDE_TOP = 5'd19;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2d;
	localparam logic [7:0] ASCII_NUL = 8'h00;

	localparam logic [63:0] POW10 [20] = '{
		64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
		64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
		64'd100000000000, 64'd1000000000000, 64'd10000000000000,
		64'd100000000000000, 64'd1000000000000000, 64'd10000000000000000,
		64'd100000000000000000, 64'd1000000000000000000,
		64'd10000000000000000000
	};

	typedef enum logic [1:0] {
		SEL_SIGN,
		SEL_DIGIT,
		SEL_TERM
	} char_sel_t;

	typedef struct packed {
		logic             load;
		logic             step;
		logic [POS_W-1:0] pos;
		logic             out_load;
		char_sel_t        sel;
		logic             out_last;
	} cmd_t;

	typedef struct packed {
		logic neg;
		logic digit_nz;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

[rtl/bda_datapath.sv]
// Datapath of the binary to decimal ASCII converter: magnitude register,
// digit extraction against the power-of-ten table and the output register.
// Depends on bda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bda_datapath (
	input  wire              clk,
	input  wire              arst_n,
	input  wire [63:0]       value,
	input  wire              is_signed,
	input  wire              operand_wide,
	input  bda_pkg::cmd_t    cmd,
	output bda_pkg::status_t status,
	input  wire              out_ready,
	output logic             out_valid,
	output logic [7:0]       char_code,
	output logic             last
);
	import bda_pkg::*;

	logic [63:0]        mag_q;
	logic [63:0]        masked;
	logic [63:0]        negated;
	logic               neg;
	logic [67:0]        mult [10];
	logic [DIGIT_W-1:0] digit;
	logic [67:0]        sub;
	logic               out_valid_q;
	logic [7:0]         char_q;
	logic               last_q;
	logic [7:0]         char_next;

	assign masked = operand_wide ? value : {32'd0, value[31:0]};
	assign neg = is_signed && (operand_wide ? value[63] : value[31]);
	assign negated = operand_wide ? (~masked + 64'd1) : {32'd0, ~value[31:0] + 32'd1};

	// Quotient digit by comparing against all nine multiples at once; the
	// magnitude is always below ten times the current power here.
	always_comb begin
		digit = '0;
		sub = '0;
		for (int k = 0; k < 10; k++) begin
			mult[k] = {4'd0, POW10[cmd.pos]} * 68'(k);
		end
		for (int k = 1; k < 10; k++) begin
			if ({4'd0, mag_q} >= mult[k]) begin
				digit = DIGIT_W'(k);
				sub = mult[k];
			end
		end
	end

	always_comb begin
		case (cmd.sel)
			SEL_SIGN:  char_next = ASCII_MINUS;
			SEL_DIGIT: char_next = ASCII_ZERO + {4'd0, digit};
			SEL_TERM:  char_next = ASCII_NUL;
			default:   char_next = ASCII_NUL;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= neg ? negated : masked;
		end else if (cmd.step) begin
			mag_q <= mag_q - sub[63:0];
		end
		if (cmd.out_load) begin
			char_q <= char_next;
			last_q <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.neg = neg;
	assign status.digit_nz = (digit != '0);
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last = last_q;

endmodule

`default_nettype wire

[rtl/bda_ctrl.sv]
// Controller of the binary to decimal ASCII converter: sequences sign,
// digit positions and terminator, and handles leading zero suppression.
// Depends on bda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bda_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire              operand_wide,
	input  wire [7:0]        digit_count,
	input  wire              leading_zeros,
	input  wire              no_terminator,
	input  bda_pkg::status_t status,
	output bda_pkg::cmd_t    cmd
);
	import bda_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SIGN,
		ST_DIGIT,
		ST_TERM
	} state_t;

	state_t           state_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] keep_q;
	logic             lead_q;
	logic             no_term_q;
	logic [POS_W-1:0] max_digits;
	logic [POS_W-1:0] keep_in;
	logic             accept;
	logic             emit;

	assign max_digits = operand_wide ? WIDE_DIGITS : NARROW_DIGITS;
	assign keep_in = (digit_count == 8'd0 || digit_count > {3'd0, max_digits})
		? max_digits : digit_count[POS_W-1:0];

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;

	// Positions at or above the kept count are stripped without output,
	// which leaves the magnitude modulo the kept power of ten.
	assign emit = (pos_q < keep_q) && (lead_q || status.digit_nz || pos_q == '0);

	always_comb begin
		cmd = '0;
		cmd.load = accept;
		cmd.pos = pos_q;
		cmd.sel = SEL_DIGIT;
		case (state_q)
			ST_IDLE: begin
			end
			ST_SIGN: begin
				cmd.sel = SEL_SIGN;
				cmd.out_load = status.out_free;
			end
			ST_DIGIT: begin
				cmd.step = emit ? status.out_free : 1'b1;
				cmd.out_load = emit && status.out_free;
				cmd.out_last = (pos_q == '0) && no_term_q;
			end
			ST_TERM: begin
				cmd.sel = SEL_TERM;
				cmd.out_load = status.out_free;
				cmd.out_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			keep_q <= '0;
			lead_q <= 1'b0;
			no_term_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pos_q <= operand_wide ? WIDE_TOP : NARROW_TOP;
						keep_q <= keep_in;
						lead_q <= leading_zeros;
						no_term_q <= no_terminator;
						state_q <= status.neg ? ST_SIGN : ST_DIGIT;
					end
				end
				ST_SIGN: begin
					if (status.out_free) begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (cmd.step) begin
						if (cmd.out_load) begin
							lead_q <= 1'b1;
						end
						if (pos_q == '0) begin
							state_q <= no_term_q ? ST_IDLE : ST_TERM;
						end else begin
							pos_q <= pos_q - POS_W'(1);
						end
					end
				end
				ST_TERM: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!cmd.out_load && !cmd.step))
		else $error("bda_ctrl: datapath commanded while idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (pos_q <= WIDE_TOP && keep_q <= WIDE_DIGITS && keep_q != '0))
		else $error("bda_ctrl: digit position or kept count out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGIT && pos_q >= keep_q) |-> !cmd.out_load)
		else $error("bda_ctrl: stripped digit position produced a character");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TERM) |-> !no_term_q)
		else $error("bda_ctrl: terminator sent although suppressed");

endmodule

`default_nettype wire

[rtl/binary_to_decimal_ascii_core.sv]
// Binary to decimal ASCII converter, top level.
// The first character is registered in the output register once the controller has left idle. It is delayed
// further by each stripped or suppressed digit position ahead of it and by each output stall.
// An item passes through an optional sign, 10 or 20 digit positions and an optional terminator.
// Input is taken only between items; a result waiting at the output does not block the next.
// Reset (arst_n low, asynchronous) returns the controller to idle and empties the output.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_ascii_core (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire [63:0] value,
	input  wire        is_signed,
	input  wire        operand_wide,
	input  wire [7:0]  digit_count,
	input  wire        leading_zeros,
	input  wire        no_terminator,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] char_code,
	output logic       last
);
	import bda_pkg::*;

	cmd_t    cmd;
	status_t status;

	bda_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operand_wide  (operand_wide),
		.digit_count   (digit_count),
		.leading_zeros (leading_zeros),
		.no_terminator (no_terminator),
		.status        (status),
		.cmd           (cmd)
	);

	bda_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.is_signed    (is_signed),
		.operand_wide (operand_wide),
		.cmd          (cmd),
		.status       (status),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.char_code    (char_code),
		.last         (last)
	);

endmodule

`default_nettype wire

[test/bda_stream_checker.sv]
// Stream checker for the binary to decimal ASCII converter.
// Watches both channels, predicts the characters of each input transaction and compares them in order.
// Depends on bda_pkg for the digit counts and character codes.
`timescale 1ns / 1ps

module bda_stream_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	input  wire        in_ready,
	input  wire [63:0] value,
	input  wire        is_signed,
	input  wire        operand_wide,
	input  wire [7:0]  digit_count,
	input  wire        leading_zeros,
	input  wire        no_terminator,
	input  wire        out_valid,
	input  wire        out_ready,
	input  wire [7:0]  char_code,
	input  wire        last,
	output int         fail_count,
	output int         pending
);

	import bda_pkg::*;

	typedef struct packed {
		logic [7:0] code;
		logic       fin;
	} char_exp_t;

	char_exp_t expected_chars[$];
	char_exp_t head;
	int        chars_seen;

	initial begin
		fail_count = 0;
		pending = 0;
		chars_seen = 0;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t char %0d: %s", $realtime, chars_seen, what);
		fail_count++;
	endtask

	// Builds the character sequence of one operand and queues it.
	task automatic predict_decimal_chars(input logic [63:0] v, input logic sgn,
			input logic wide, input logic [7:0] cnt, input logic lz, input logic nt);
		logic [63:0] mag;
		logic [3:0]  digs [20];
		logic [7:0]  seq [22];
		logic        showing;
		int          n;
		int          width;
		int          keep;
		n = 0;
		width = wide ? WIDE_DIGITS : NARROW_DIGITS;
		mag = wide ? v : {32'd0, v[31:0]};
		if (sgn && (wide ? v[63] : v[31])) begin
			seq[n] = ASCII_MINUS;
			n++;
			mag = wide ? (64'd0 - mag) : {32'd0, 32'd0 - mag[31:0]};
		end
		keep = (cnt == 0 || cnt > width) ? width : cnt;
		// Low digit first; keeping only the low digits is the modulo.
		for (int k = 0; k < 20; k++) begin
			digs[k] = 4'(mag % 10);
			mag = mag / 10;
		end
		showing = lz;
		for (int k = keep - 1; k > 0; k--) begin
			if (digs[k] != 0)
				showing = 1'b1;
			if (showing) begin
				seq[n] = ASCII_ZERO + {4'd0, digs[k]};
				n++;
			end
		end
		seq[n] = ASCII_ZERO + {4'd0, digs[0]};
		n++;
		if (!nt) begin
			seq[n] = ASCII_NUL;
			n++;
		end
		for (int i = 0; i < n; i++)
			expected_chars.push_back('{code: seq[i], fin: (i == n - 1)});
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_decimal_chars(value, is_signed, operand_wide, digit_count,
					leading_zeros, no_terminator);
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected char 0x%02h", char_code));
				end else begin
					head = expected_chars.pop_front();
					if (char_code !== head.code)
						report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
							char_code, head.code));
					if (last !== head.fin)
						report_mismatch($sformatf("last %b, expected %b", last, head.fin));
				end
				chars_seen++;
			end
			pending = expected_chars.size();
		end
	end

endmodule

[test/tb_binary_to_decimal_ascii_core.sv]
// Testbench top for binary_to_decimal_ascii_core.
// Drives directed and random operands with random idling on both sides; bda_stream_checker
// does the prediction and comparison, this module gives the verdict.
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii_core;

	localparam int RANDOM_ITEMS = 400;
	localparam int QUIET_TAIL = 50;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] value = 64'd0;
	logic        is_signed = 1'b0;
	logic        operand_wide = 1'b0;
	logic [7:0]  digit_count = 8'd0;
	logic        leading_zeros = 1'b0;
	logic        no_terminator = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  char_code;
	logic        last;

	logic        in_taken = 1'b0;
	logic        bursts_on = 1'b1;
	logic        hold_req = 1'b0;
	int          quiet_cycles = 0;
	int          fail_count;
	int          pending;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	binary_to_decimal_ascii_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.value         (value),
		.is_signed     (is_signed),
		.operand_wide  (operand_wide),
		.digit_count   (digit_count),
		.leading_zeros (leading_zeros),
		.no_terminator (no_terminator),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.char_code     (char_code),
		.last          (last)
	);

	bda_stream_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.value         (value),
		.is_signed     (is_signed),
		.operand_wide  (operand_wide),
		.digit_count   (digit_count),
		.leading_zeros (leading_zeros),
		.no_terminator (no_terminator),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.char_code     (char_code),
		.last          (last),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// Input handshake seen at the rising edge, read back at the next falling edge.
	always @(posedge clk)
		in_taken <= in_valid && in_ready;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Called at a falling edge; returns at a falling edge after the transaction.
	task automatic send_operand(input logic [63:0] v, input logic sgn, input logic wide,
			input logic [7:0] cnt, input logic lz, input logic nt);
		value = v;
		is_signed = sgn;
		operand_wide = wide;
		digit_count = cnt;
		leading_zeros = lz;
		no_terminator = nt;
		in_valid = 1'b1;
		do @(negedge clk); while (!in_taken);
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
	endtask

	function automatic logic [63:0] pick_operand(input logic wide);
		logic [63:0] v;
		logic [63:0] p;
		int          k;
		case ($urandom_range(0, 5))
			0: v = {$urandom, $urandom};
			1: v = $urandom_range(0, 999);
			2: begin
				p = 64'd1;
				k = $urandom_range(1, wide ? 19 : 9);
				repeat (k) p = p * 10;
				v = p + $urandom_range(0, 2) - 1;
			end
			3: v = 64'd0 - $urandom_range(1, 999);
			4: begin
				case ($urandom_range(0, 3))
					0: v = 64'd0;
					1: v = ~64'd0;
					2: v = wide ? {1'b1, 63'd0} : 64'h8000_0000;
					default: v = wide ? {1'b0, {63{1'b1}}} : 64'h7FFF_FFFF;
				endcase
			end
			default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
		endcase
		// upper half is ignored by a narrow operand, so keep it busy
		if (!wide)
			v[63:32] = $urandom;
		return v;
	endfunction

	task automatic send_random_operand();
		logic       w;
		logic [7:0] cnt;
		int         mx;
		w = $urandom_range(0, 1);
		mx = w ? 20 : 10;
		case ($urandom_range(0, 9))
			0, 1, 2: cnt = 8'd0;
			3, 4, 5, 6: cnt = $urandom_range(1, mx);
			7, 8: cnt = $urandom_range(mx + 1, 255);
			default: cnt = $urandom;
		endcase
		send_operand(pick_operand(w), $urandom_range(0, 1), w, cnt, $urandom_range(0, 2) == 0,
			$urandom_range(0, 1));
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready = 1'b0;
				for (int c = 0; c < HOLD_CYCLES; c++)
					@(negedge clk);
			end else if (bursts_on && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
				@(negedge clk);
			end
		end
	end

	initial begin
		int hold_at;
		hold_at = $urandom_range(40, 120);
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_operand(64'd0, 0, 0, 8'd0, 0, 0);
		send_operand(64'hFFFF_FFFF, 0, 0, 8'd0, 0, 0);
		send_operand(64'h8000_0000, 1, 0, 8'd0, 0, 0);
		send_operand(64'h7FFF_FFFF, 1, 0, 8'd0, 0, 1);
		send_operand(~64'd0, 0, 1, 8'd0, 0, 0);
		// longest sequence: sign, twenty forced digits, terminator
		send_operand(64'h8000_0000_0000_0000, 1, 1, 8'd0, 1, 0);
		send_operand(~64'd0, 1, 1, 8'd0, 0, 0);
		send_operand(~64'd0, 1, 0, 8'd0, 0, 0);
		send_operand(64'd0, 0, 1, 8'd0, 1, 0);
		send_operand(64'd1234567890, 0, 0, 8'd3, 0, 0);
		send_operand(64'd1234567000, 0, 0, 8'd3, 0, 0);
		send_operand(64'd1234567000, 0, 0, 8'd3, 1, 0);
		// negative with all kept digits zero still shows the sign
		send_operand(64'h0000_0000_FFFF_FC18, 1, 0, 8'd3, 0, 0);
		send_operand(64'd12345, 0, 1, 8'd1, 0, 1);
		send_operand(64'd12345, 0, 0, 8'd10, 1, 0);
		send_operand(~64'd0, 0, 1, 8'd20, 0, 0);
		send_operand(64'd12345, 0, 0, 8'd11, 0, 0);
		send_operand(64'd12345, 0, 1, 8'd21, 0, 0);
		send_operand(64'hDEAD_BEEF_0000_0005, 0, 0, 8'd0, 0, 0);
		send_operand(64'hDEAD_BEEF_8000_0005, 1, 0, 8'hFF, 0, 1);
		send_operand(64'd10000000000000000000, 0, 1, 8'd0, 0, 0);
		send_operand(64'd9999999999, 0, 1, 8'd10, 1, 0);
		send_operand(~64'd0, 1, 1, 8'hFF, 1, 1);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - QUIET_TAIL)
				bursts_on = 1'b0;
			if (i == hold_at)
				hold_req = 1'b1;
			send_random_operand();
		end
		in_valid = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
